// ===== src/csvp_pkg.sv =====
// Shared types and constants for the signed decimal field parser.
// Holds the character codes, result status codes and the queue item layout.
// No dependencies.
package csvp_pkg;

   localparam int VALUE_BITS = 16;
   localparam int FIELD_BITS = 16;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] DIGIT_MAX  = 8'd9;
   localparam logic [VALUE_BITS-1:0] RADIX = VALUE_BITS'(10);

   localparam logic [1:0] SKIP_CHARS = 2'd2;

   typedef enum logic [2:0] {
      ST_MORE    = 3'd0,
      ST_OK      = 3'd1,
      ST_EMPTY   = 3'd2,
      ST_BADCHAR = 3'd3,
      ST_EARLY   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      CLS_TERM,
      CLS_COMMA,
      CLS_MINUS,
      CLS_DIGIT,
      CLS_BAD
   } class_type;

   typedef struct packed {
      logic       start;
      logic [3:0] goal;
      class_type  cls;
      logic [3:0] digit;
   } item_type;

endpackage

// ===== src/csvp_front.sv =====
// Front stage of the field parser: accepts characters and classifies them.
// Produces one registered queue item per transfer; uses csvp_pkg.
module csvp_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_char_in,
   input  logic               req_line_start,
   input  logic [3:0]         req_wanted_values,
   output logic               push,
   output csvp_pkg::item_type push_item,
   input  logic               queue_ready
);

   logic               stage_valid_ff, stage_valid_in;
   csvp_pkg::item_type stage_item_ff, stage_item_in;
   logic               accept;
   logic [7:0]         digit_code;

   assign push      = stage_valid_ff && queue_ready;
   assign push_item = stage_item_ff;
   assign req_stall = stage_valid_ff && !queue_ready;
   assign accept    = req_valid && !req_stall;
   assign digit_code = req_char_in - csvp_pkg::CHAR_ZERO;

   always_comb begin
      stage_item_in.start = req_line_start;
      stage_item_in.goal  = (req_wanted_values == 4'd0) ? 4'd1 : req_wanted_values;
      stage_item_in.digit = digit_code[3:0];
      if (req_char_in == csvp_pkg::CHAR_NUL) begin
         stage_item_in.cls = csvp_pkg::CLS_TERM;
      end else if (req_char_in == csvp_pkg::CHAR_COMMA) begin
         stage_item_in.cls = csvp_pkg::CLS_COMMA;
      end else if (req_char_in == csvp_pkg::CHAR_MINUS) begin
         stage_item_in.cls = csvp_pkg::CLS_MINUS;
      end else if (digit_code <= csvp_pkg::DIGIT_MAX) begin
         stage_item_in.cls = csvp_pkg::CLS_DIGIT;
      end else begin
         stage_item_in.cls = csvp_pkg::CLS_BAD;
      end
   end

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (push) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      if (accept) begin
         stage_item_ff <= stage_item_in;
      end
   end

endmodule

// ===== src/csvp_queue.sv =====
// Two-entry queue of classified characters between front and back stages.
// Uses csvp_pkg for the item layout.
module csvp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  csvp_pkg::item_type push_item,
   output logic               ready,
   output logic               pop_valid,
   output csvp_pkg::item_type pop_item,
   input  logic               pop
);

   csvp_pkg::item_type entry_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;

   assign ready     = (count_ff != 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== src/csvp_back.sv =====
// Back stage of the field parser: per-line state, accumulation and results.
// Drives the registered result channel; uses csvp_pkg.
module csvp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  csvp_pkg::item_type  item,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [15:0]  rsp_value,
   output logic [3:0]          rsp_value_index,
   output logic [2:0]          rsp_status,
   output logic                rsp_last
);

   localparam int AW = csvp_pkg::VALUE_BITS;
   localparam int FW = csvp_pkg::FIELD_BITS;

   logic [1:0]    pos_ff, pos_in;
   logic [AW-1:0] acc_ff, acc_in;
   logic          neg_ff, neg_in;
   logic          seen_ff, seen_in;
   logic [3:0]    stored_ff, stored_in;
   logic [3:0]    goal_ff, goal_in;
   logic          fin_ff, fin_in;

   logic                 out_valid_ff, out_valid_in;
   logic [FW-1:0]        out_value_ff, out_value_in;
   logic [3:0]           out_index_ff, out_index_in;
   csvp_pkg::status_type out_status_ff, out_status_in;
   logic                 out_last_ff, out_last_in;

   logic          emit;
   logic [AW-1:0] signed_val;
   logic [AW-1:0] acc_times_ten;
   logic [AW+FW-1:0] value_ext;

   assign pop = item_valid && (!out_valid_ff || !rsp_stall);

   assign rsp_valid       = out_valid_ff;
   assign rsp_value       = out_value_ff;
   assign rsp_value_index = out_index_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_last        = out_last_ff;

   always_comb begin
      pos_in    = pos_ff;
      acc_in    = acc_ff;
      neg_in    = neg_ff;
      seen_in   = seen_ff;
      stored_in = stored_ff;
      goal_in   = goal_ff;
      fin_in    = fin_ff;
      emit          = 1'b0;
      out_value_in  = '0;
      out_index_in  = stored_ff;
      out_status_in = csvp_pkg::ST_MORE;
      out_last_in   = 1'b0;

      if (item.start) begin
         pos_in    = 2'd0;
         acc_in    = '0;
         neg_in    = 1'b0;
         seen_in   = 1'b0;
         stored_in = 4'd0;
         goal_in   = item.goal;
         fin_in    = 1'b0;
      end
      out_index_in  = stored_in;
      acc_times_ten = acc_in * csvp_pkg::RADIX;
      signed_val    = neg_in ? (AW'(0) - acc_in) : acc_in;
      value_ext     = {{FW{1'b0}}, signed_val};

      if (!fin_in) begin
         if (pos_in < csvp_pkg::SKIP_CHARS) begin
            pos_in = pos_in + 2'd1;
            if (item.cls == csvp_pkg::CLS_TERM) begin
               emit          = 1'b1;
               out_status_in = csvp_pkg::ST_EARLY;
               out_last_in   = 1'b1;
            end
         end else begin
            case (item.cls) inside
               csvp_pkg::CLS_TERM, csvp_pkg::CLS_COMMA: begin
                  emit = 1'b1;
                  if (!seen_in) begin
                     out_status_in = csvp_pkg::ST_EMPTY;
                     out_last_in   = 1'b1;
                  end else begin
                     out_value_in = value_ext[FW-1:0];
                     acc_in       = '0;
                     neg_in       = 1'b0;
                     seen_in      = 1'b0;
                     stored_in    = stored_in + 4'd1;
                     if (stored_in == goal_in) begin
                        out_status_in = csvp_pkg::ST_OK;
                        out_last_in   = 1'b1;
                     end else if (item.cls == csvp_pkg::CLS_TERM) begin
                        out_status_in = csvp_pkg::ST_EARLY;
                        out_last_in   = 1'b1;
                     end
                  end
               end
               csvp_pkg::CLS_MINUS: begin
                  neg_in = 1'b1;
               end
               csvp_pkg::CLS_DIGIT: begin
                  acc_in  = acc_times_ten + {{(AW-4){1'b0}}, item.digit};
                  seen_in = 1'b1;
               end
               default: begin
                  emit          = 1'b1;
                  out_status_in = csvp_pkg::ST_BADCHAR;
                  out_last_in   = 1'b1;
               end
            endcase
         end
         if (out_last_in) begin
            fin_in = 1'b1;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (pop) begin
         out_valid_in = emit;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 2'd0;
         acc_ff       <= '0;
         neg_ff       <= 1'b0;
         seen_ff      <= 1'b0;
         stored_ff    <= 4'd0;
         goal_ff      <= 4'd1;
         fin_ff       <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (pop) begin
            pos_ff    <= pos_in;
            acc_ff    <= acc_in;
            neg_ff    <= neg_in;
            seen_ff   <= seen_in;
            stored_ff <= stored_in;
            goal_ff   <= goal_in;
            fin_ff    <= fin_in;
         end
      end
      if (pop && emit) begin
         out_value_ff  <= out_value_in;
         out_index_ff  <= out_index_in;
         out_status_ff <= out_status_in;
         out_last_ff   <= out_last_in;
      end
   end

endmodule

// ===== src/csv_signed_decimal_parser.sv =====
// Top level of the comma separated signed decimal field parser.
// Instantiates csvp_front, csvp_queue and csvp_back; uses csvp_pkg.
//
//   Channel  Direction  Handshake          Payload
//   req      in         req_valid/stall    char_in, line_start, wanted_values
//   rsp      out        rsp_valid/stall    value, value_index, status, last
//
// One character is taken per cycle unless req_stall is high; results are registered.
// The back stage updates the line state once per cycle when it pops, setting the rate.
// Reset clears the line state so the block idles until a line start.
// A two-entry queue lets the input flow while rsp_stall holds a result, until full.
module csv_signed_decimal_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_char_in,
   input  logic               req_line_start,
   input  logic [3:0]         req_wanted_values,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_value,
   output logic [3:0]         rsp_value_index,
   output logic [2:0]         rsp_status,
   output logic               rsp_last
);

   logic               push;
   csvp_pkg::item_type push_item;
   logic               queue_ready;
   logic               pop_valid;
   csvp_pkg::item_type pop_item;
   logic               pop;

   csvp_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_char_in       (req_char_in),
      .req_line_start    (req_line_start),
      .req_wanted_values (req_wanted_values),
      .push              (push),
      .push_item         (push_item),
      .queue_ready       (queue_ready)
   );

   csvp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .ready     (queue_ready),
      .pop_valid (pop_valid),
      .pop_item  (pop_item),
      .pop       (pop)
   );

   csvp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (pop_valid),
      .item            (pop_item),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_value       (rsp_value),
      .rsp_value_index (rsp_value_index),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last)
   );

   a_last_matches_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_status != csvp_pkg::ST_MORE)))
      else $error("last flag disagrees with status");

   a_error_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == csvp_pkg::ST_EMPTY ||
                     rsp_status == csvp_pkg::ST_BADCHAR)) |-> (rsp_value == 16'sd0))
      else $error("error result carries a non-zero value");

   a_status_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == csvp_pkg::ST_MORE || rsp_status == csvp_pkg::ST_OK ||
                     rsp_status == csvp_pkg::ST_EMPTY || rsp_status == csvp_pkg::ST_BADCHAR ||
                     rsp_status == csvp_pkg::ST_EARLY))
      else $error("result status out of range");

endmodule

// ===== verif/tb_csv_signed_decimal_parser.sv =====
// Self-checking testbench for csv_signed_decimal_parser: directed and random command lines.
// A small tracker class predicts each parsed field and checks the result channel in order.
// Depends on csvp_pkg and the csv_signed_decimal_parser top level only.
module tb_csv_signed_decimal_parser;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [15:0]          value;
      logic [3:0]           index;
      csvp_pkg::status_type status;
      logic                 last;
   } field_result_type;

   class field_value_tracker;
      logic [1:0]       skip_count;
      logic [15:0]      accum;
      bit               minus_seen;
      bit               any_digit;
      logic [3:0]       fields_done;
      logic [3:0]       fields_goal;
      bit               line_closed;
      field_result_type pending_fields[$];
      int               mismatches;
      int               lines_begun;
      int               live_chars;
      int               fields_checked;
      int               status_seen[5];

      function new();
         skip_count  = 2'd0;
         accum       = '0;
         minus_seen  = 0;
         any_digit   = 0;
         fields_done = 4'd0;
         fields_goal = 4'd1;
         line_closed = 1;
         mismatches  = 0;
         lines_begun = 0;
         live_chars  = 0;
         fields_checked = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function void add_field(logic [15:0] v, logic [3:0] idx,
                              csvp_pkg::status_type st, logic fin);
         field_result_type r;
         r.value  = v;
         r.index  = idx;
         r.status = st;
         r.last   = fin;
         pending_fields.push_back(r);
         if (fin)
            line_closed = 1;
      endfunction

      function void note_char(logic [7:0] c, logic s, logic [3:0] w);
         logic [7:0]  d;
         logic [15:0] v;
         logic [3:0]  idx;
         if (s) begin
            skip_count  = 2'd0;
            accum       = '0;
            minus_seen  = 0;
            any_digit   = 0;
            fields_done = 4'd0;
            fields_goal = (w == 4'd0) ? 4'd1 : w;
            line_closed = 0;
            lines_begun++;
         end
         if (line_closed)
            return;
         live_chars++;
         if (skip_count < csvp_pkg::SKIP_CHARS) begin
            skip_count++;
            if (c == csvp_pkg::CHAR_NUL)
               add_field('0, fields_done, csvp_pkg::ST_EARLY, 1'b1);
            return;
         end
         if (c == csvp_pkg::CHAR_NUL || c == csvp_pkg::CHAR_COMMA) begin
            if (!any_digit) begin
               add_field('0, fields_done, csvp_pkg::ST_EMPTY, 1'b1);
               return;
            end
            v = minus_seen ? -accum : accum;
            idx = fields_done;
            accum = '0;
            minus_seen = 0;
            any_digit = 0;
            fields_done = fields_done + 4'd1;
            if (fields_done == fields_goal)
               add_field(v, idx, csvp_pkg::ST_OK, 1'b1);
            else if (c == csvp_pkg::CHAR_NUL)
               add_field(v, idx, csvp_pkg::ST_EARLY, 1'b1);
            else
               add_field(v, idx, csvp_pkg::ST_MORE, 1'b0);
            return;
         end
         if (c == csvp_pkg::CHAR_MINUS) begin
            minus_seen = 1;
            return;
         end
         d = c - csvp_pkg::CHAR_ZERO;
         if (d > csvp_pkg::DIGIT_MAX) begin
            add_field('0, fields_done, csvp_pkg::ST_BADCHAR, 1'b1);
            return;
         end
         accum = accum * csvp_pkg::RADIX + d;
         any_digit = 1;
      endfunction

      function void check_field(logic [15:0] v, logic [3:0] idx, logic [2:0] st, logic fin);
         field_result_type e;
         if (pending_fields.size() == 0) begin
            $display("%0t: unexpected result: value %0d index %0d status %0d last %0d",
                     $time, $signed(v), idx, st, fin);
            mismatches++;
            return;
         end
         e = pending_fields.pop_front();
         fields_checked++;
         status_seen[e.status]++;
         if (v !== e.value) begin
            $display("%0t: value mismatch: expected %0d, actual %0d",
                     $time, $signed(e.value), $signed(v));
            mismatches++;
         end
         if (idx !== e.index) begin
            $display("%0t: value_index mismatch: expected %0d, actual %0d", $time, e.index, idx);
            mismatches++;
         end
         if (st !== e.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d", $time, e.status, st);
            mismatches++;
         end
         if (fin !== e.last) begin
            $display("%0t: last mismatch: expected %0d, actual %0d", $time, e.last, fin);
            mismatches++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_char_in = 8'd0;
   logic               req_line_start = 1'b0;
   logic [3:0]         req_wanted_values = 4'd0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_value;
   logic [3:0]         rsp_value_index;
   logic [2:0]         rsp_status;
   logic               rsp_last;

   field_value_tracker tracker = new();
   bit                 idling_on = 1;
   bit                 long_hold_req = 0;
   bit                 long_hold_busy = 0;

   csv_signed_decimal_parser u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_char_in       (req_char_in),
      .req_line_start    (req_line_start),
      .req_wanted_values (req_wanted_values),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_value         (rsp_value),
      .rsp_value_index   (rsp_value_index),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5ms;
      $display("%0t: timed out with %0d results outstanding", $time,
               tracker.pending_fields.size());
      $display("[csv_signed_decimal_parser] ERROR");
      $finish;
   end

   // Result side: checks every transfer and stalls in random bursts or one long hold.
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            tracker.check_field(rsp_value, rsp_value_index, rsp_status, rsp_last);
         if (hold_left > 0) begin
            hold_left--;
            if (hold_left == 0) begin
               rsp_stall <= 1'b0;
               long_hold_busy = 0;
            end
         end else if (long_hold_req) begin
            long_hold_req = 0;
            long_hold_busy = 1;
            hold_left = 120;
            rsp_stall <= 1'b1;
         end else if (idling_on && $urandom_range(0, 9) == 0) begin
            hold_left = $urandom_range(1, 14);
            rsp_stall <= 1'b1;
         end
      end
   end

   task automatic send_char(input logic [7:0] c, input logic s, input logic [3:0] w);
      if (idling_on && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_char_in       <= c;
      req_line_start    <= s;
      req_wanted_values <= w;
      do
         @(posedge clock);
      while (req_stall);
      tracker.note_char(c, s, w);
   endtask

   task automatic send_text(input string txt, input logic [3:0] w, input bit with_nul);
      for (int i = 0; i < txt.len(); i++)
         send_char(txt[i], i == 0, (i == 0) ? w : 4'($urandom_range(0, 15)));
      if (with_nul)
         send_char(csvp_pkg::CHAR_NUL, 1'b0, 4'($urandom_range(0, 15)));
   endtask

   task automatic random_line();
      logic [7:0]  chars[$];
      logic [3:0]  w;
      int unsigned goal, nfields, ndig, kind, pos;
      w = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 4));
      goal = (w == 4'd0) ? 1 : w;
      kind = $urandom_range(0, 99);
      nfields = (kind >= 78 && kind < 88) ? $urandom_range(1, goal) : goal;
      chars.push_back(8'($urandom_range(1, 255)));
      chars.push_back(8'($urandom_range(1, 255)));
      for (int f = 0; f < nfields; f++) begin
         if ($urandom_range(0, 3) == 0)
            chars.push_back(csvp_pkg::CHAR_MINUS);
         ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 7) : $urandom_range(1, 3);
         for (int k = 0; k < ndig; k++) begin
            chars.push_back(csvp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 40) == 0)
               chars.push_back(csvp_pkg::CHAR_MINUS);
         end
         if (f == nfields - 1 && $urandom_range(0, 1) == 0)
            chars.push_back(csvp_pkg::CHAR_NUL);
         else
            chars.push_back(csvp_pkg::CHAR_COMMA);
      end
      pos = $urandom_range(0, chars.size() - 1);
      if (kind >= 88 && kind < 93)
         chars[pos] = 8'($urandom_range(0, 255));
      else if (kind >= 93 && kind < 96)
         chars.insert((pos < 2) ? 2 : pos, csvp_pkg::CHAR_COMMA);
      else if (kind >= 96)
         while (chars.size() > ((pos == 0) ? 1 : pos))
            void'(chars.pop_back());
      if ($urandom_range(0, 5) == 0)
         repeat ($urandom_range(1, 4)) chars.push_back(8'($urandom_range(0, 255)));
      foreach (chars[i])
         send_char(chars[i], i == 0, (i == 0) ? w : 4'($urandom_range(0, 15)));
   endtask

   initial begin
      int  waited;
      bit  pressure_done;
      pressure_done = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_text("X,9,-0", 4'd15, 1);
      send_char(csvp_pkg::CHAR_NUL, 1'b1, 4'd2);
      send_text("P", 4'd1, 1);
      send_text("Q:,", 4'd0, 0);
      send_text("R:5/", 4'd1, 0);
      send_text("S:", 4'd1, 0);
      send_char(8'hFF, 1'b0, 4'd0);
      send_text("T:7", 4'd3, 1);
      send_char(csvp_pkg::CHAR_ZERO, 1'b0, 4'd0);

      while (tracker.live_chars < 1700) begin
         if (!pressure_done && tracker.live_chars > 600) begin
            // Hold the result side off long enough for the input to back up.
            long_hold_req = 1;
            wait (long_hold_busy);
            send_text("L:1,2,3,4,5,6,7,8,9,10,11,12,13,-14,15", 4'd15, 1);
            pressure_done = 1;
         end
         if (tracker.live_chars > 1500)
            idling_on = 0;
         random_line();
      end
      req_valid <= 1'b0;

      waited = 0;
      while (tracker.pending_fields.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      if (tracker.pending_fields.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time,
                  tracker.pending_fields.size());
         tracker.mismatches++;
      end

      $display("Parsed %0d lines and %0d live characters; checked %0d results.",
               tracker.lines_begun, tracker.live_chars, tracker.fields_checked);
      $display("Statuses seen: %0d more, %0d ok, %0d empty, %0d bad char, %0d early.",
               tracker.status_seen[0], tracker.status_seen[1], tracker.status_seen[2],
               tracker.status_seen[3], tracker.status_seen[4]);
      if (tracker.mismatches == 0)
         $display("[csv_signed_decimal_parser] OK");
      else
         $display("[csv_signed_decimal_parser] ERROR");
      $finish;
   end

endmodule
